// ----- rtl/v3n_pkg.sv -----
// Shared types and constants for the 3D vector normalizer.
`default_nettype none
package v3n_pkg;
    localparam int unsigned COMP_W = 32;
    localparam int unsigned SUM_W = 64;
    localparam int unsigned ROOT_W = 32;
    localparam int unsigned UNIT_W = 16;
    localparam int unsigned QUO_W = 15;
    localparam int unsigned UNIT_SHIFT = 14;

    // Lane order of components
    localparam int unsigned LANE_X = 0;
    localparam int unsigned LANE_Y = 1;
    localparam int unsigned LANE_Z = 2;
    localparam int unsigned LANES = 3;

    typedef logic [COMP_W-1:0] t_comp;
    typedef logic [QUO_W-1:0] t_quo;

    // Sideband carried along with the length computation
    typedef struct packed {
        t_comp [LANES-1:0] mag;
        logic  [LANES-1:0] neg;
    } t_side;
endpackage
`default_nettype wire

// ----- rtl/v3n_square.sv -----
// Absolute values, squares and sum of squares (three stages).
`default_nettype none
module v3n_square import v3n_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [COMP_W-1:0] i_vec_x,
    input  wire logic [COMP_W-1:0] i_vec_y,
    input  wire logic [COMP_W-1:0] i_vec_z,
    output logic                   o_valid,
    output logic [SUM_W-1:0]       o_sum,
    output t_side                  o_side
);
    logic [2:0]              r_v;
    t_side                   r_side1, r_side2, r_side3;
    logic [LANES-1:0][SUM_W-1:0] r_sq;
    logic [SUM_W-1:0]        r_sum;
    t_side                   n_side1;
    t_comp [LANES-1:0]       w_in;

    assign w_in[LANE_X] = i_vec_x;
    assign w_in[LANE_Y] = i_vec_y;
    assign w_in[LANE_Z] = i_vec_z;

    // Sign and magnitude of each component
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_side1.neg[l] = w_in[l][COMP_W-1];
            n_side1.mag[l] = w_in[l][COMP_W-1] ? (~w_in[l] + 1'b1) : w_in[l];
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    // Data stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side1 <= n_side1;
            r_side2 <= r_side1;
            r_side3 <= r_side2;
            for (int l = 0; l < LANES; l++) begin
                r_sq[l] <= SUM_W'(r_side1.mag[l]) * SUM_W'(r_side1.mag[l]);
            end
            r_sum <= r_sq[LANE_X] + r_sq[LANE_Y] + r_sq[LANE_Z];
        end
    end

    assign o_valid = r_v[2];
    assign o_sum   = r_sum;
    assign o_side  = r_side3;
endmodule
`default_nettype wire

// ----- rtl/v3n_sqrt.sv -----
// Integer square root, one result bit per pipeline stage.
`default_nettype none
module v3n_sqrt import v3n_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [SUM_W-1:0]  i_rad,
    input  wire t_side             i_side,
    output logic                   o_valid,
    output logic [ROOT_W-1:0]      o_root,
    output t_side                  o_side
);
    localparam int unsigned REM_W = ROOT_W + 2;

    logic [ROOT_W-1:0]             r_v;
    logic [ROOT_W-1:0][REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0][ROOT_W-1:0] r_root;
    logic [ROOT_W-1:0][SUM_W-1:0]  r_rad;
    t_side [ROOT_W-1:0]            r_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[ROOT_W-2:0], i_valid};
        end
    end

    for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
        logic [REM_W-1:0]  w_rem_in;
        logic [ROOT_W-1:0] w_root_in;
        logic [SUM_W-1:0]  w_rad_in;
        t_side             w_side_in;
        logic [REM_W:0]    w_sh;
        logic [REM_W:0]    w_trial;
        logic              w_ge;

        if (s == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_rad_in  = i_rad;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_rem_in  = r_rem[s-1];
            assign w_root_in = r_root[s-1];
            assign w_rad_in  = r_rad[s-1];
            assign w_side_in = r_side[s-1];
        end

        // Bring down two radicand bits and try (root*4 + 1)
        assign w_sh    = {w_rem_in[REM_W-2:0], w_rad_in[SUM_W-1 -: 2]};
        assign w_trial = {1'b0, w_root_in, 2'b01};
        assign w_ge    = (w_sh >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= w_ge ? REM_W'(w_sh - w_trial) : REM_W'(w_sh);
                r_root[s] <= {w_root_in[ROOT_W-2:0], w_ge};
                r_rad[s]  <= {w_rad_in[SUM_W-3:0], 2'b00};
                r_side[s] <= w_side_in;
            end
        end
    end

    assign o_valid = r_v[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];
endmodule
`default_nettype wire

// ----- rtl/v3n_div.sv -----
// Three restoring dividers in lockstep: quotient bit per stage of mag*2^14/len.
`default_nettype none
module v3n_div import v3n_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [ROOT_W-1:0] i_len,
    input  wire t_side             i_side,
    output logic                   o_valid,
    output logic [ROOT_W-1:0]      o_len,
    output logic [LANES-1:0]       o_neg,
    output t_quo [LANES-1:0]       o_quo
);
    localparam int unsigned STAGES = QUO_W;

    logic [STAGES-1:0]              r_v;
    logic [STAGES-1:0][ROOT_W-1:0]  r_len;
    logic [STAGES-1:0][LANES-1:0]   r_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[STAGES-2:0], i_valid};
        end
    end

    // Length and signs travel alongside
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len <= {r_len[STAGES-2:0], i_len};
            r_neg <= {r_neg[STAGES-2:0], i_side.neg};
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic [STAGES-1:0][COMP_W-1:0] r_r;
        t_quo [STAGES-1:0]             r_q;

        for (genvar s = 0; s < STAGES; s++) begin : g_stage
            logic [COMP_W:0]   w_sh;
            logic [ROOT_W-1:0] w_len;
            t_quo              w_q_in;
            logic              w_ge;

            // First stage compares mag itself; later ones shift the remainder
            if (s == 0) begin : g_first
                assign w_sh   = {1'b0, i_side.mag[l]};
                assign w_len  = i_len;
                assign w_q_in = '0;
            end else begin : g_next
                assign w_sh   = {r_r[s-1], 1'b0};
                assign w_len  = r_len[s-1];
                assign w_q_in = r_q[s-1];
            end

            assign w_ge = (w_sh >= {1'b0, w_len});

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_r[s] <= w_ge ? COMP_W'(w_sh - {1'b0, w_len}) : COMP_W'(w_sh);
                    r_q[s] <= {w_q_in[QUO_W-2:0], w_ge};
                end
            end
        end

        assign o_quo[l] = r_q[STAGES-1];
    end

    assign o_valid = r_v[STAGES-1];
    assign o_len   = r_len[STAGES-1];
    assign o_neg   = r_neg[STAGES-1];
endmodule
`default_nettype wire

// ----- rtl/vector3_normalize.sv -----
// Top level of the 3D vector normalizer: length and unit vector per item.
//
// Input channel: i_valid with i_vec_x/y/z (signed Q16.16); the block drives
// o_stall. Output channel: o_valid with o_magnitude (unsigned Q16.16),
// o_unit_x/y/z (signed Q1.14) and o_zero_length; the receiver drives i_stall.
// An item moves on a rising edge where valid is high and stall is low.
//
// Throughput: one item per cycle while the output is not stalled. From
// acceptance to the result on the output register an item passes through
// absolute value, squares and sum, the square root (one root bit per stage),
// the dividers (one quotient bit per stage) and sign and zero handling.
//
// The whole pipeline advances together; it holds only when a result waits
// on the output and i_stall is high, and then o_stall is raised. Bubbles
// keep flowing toward the output while no result is waiting.
//
// Reset (synchronous, active low) clears all valid bits; data registers
// are not reset. A zero vector gives o_zero_length high and zero units.
`default_nettype none
module vector3_normalize import v3n_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [COMP_W-1:0] i_vec_x,
    input  wire logic [COMP_W-1:0] i_vec_y,
    input  wire logic [COMP_W-1:0] i_vec_z,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [ROOT_W-1:0]      o_magnitude,
    output logic [UNIT_W-1:0]      o_unit_x,
    output logic [UNIT_W-1:0]      o_unit_y,
    output logic [UNIT_W-1:0]      o_unit_z,
    output logic                   o_zero_length
);
    logic              w_en;
    logic              w_sq_v, w_rt_v, w_dv_v;
    logic [SUM_W-1:0]  w_sum;
    t_side             w_sq_side, w_rt_side;
    logic [ROOT_W-1:0] w_root, w_dv_len;
    logic [LANES-1:0]  w_dv_neg;
    t_quo [LANES-1:0]  w_dv_quo;
    logic [LANES-1:0][UNIT_W-1:0] n_unit;
    logic              r_valid;
    logic [ROOT_W-1:0] r_magnitude;
    logic [LANES-1:0][UNIT_W-1:0] r_unit;
    logic              r_zero;

    assign w_en    = !(r_valid && i_stall);
    assign o_stall = !w_en;

    v3n_square u_square (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_vec_x (i_vec_x),
        .i_vec_y (i_vec_y),
        .i_vec_z (i_vec_z),
        .o_valid (w_sq_v),
        .o_sum   (w_sum),
        .o_side  (w_sq_side)
    );

    v3n_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sq_v),
        .i_rad   (w_sum),
        .i_side  (w_sq_side),
        .o_valid (w_rt_v),
        .o_root  (w_root),
        .o_side  (w_rt_side)
    );

    v3n_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_rt_v),
        .i_len   (w_root),
        .i_side  (w_rt_side),
        .o_valid (w_dv_v),
        .o_len   (w_dv_len),
        .o_neg   (w_dv_neg),
        .o_quo   (w_dv_quo)
    );

    // Apply signs; zero length forces zero units
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (w_dv_len == '0) begin
                n_unit[l] = '0;
            end else if (w_dv_neg[l]) begin
                n_unit[l] = UNIT_W'(~{1'b0, w_dv_quo[l]} + 1'b1);
            end else begin
                n_unit[l] = {1'b0, w_dv_quo[l]};
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= w_dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_magnitude <= w_dv_len;
            r_unit      <= n_unit;
            r_zero      <= (w_dv_len == '0);
        end
    end

    assign o_valid       = r_valid;
    assign o_magnitude   = r_magnitude;
    assign o_unit_x      = r_unit[LANE_X];
    assign o_unit_y      = r_unit[LANE_Y];
    assign o_unit_z      = r_unit[LANE_Z];
    assign o_zero_length = r_zero;

`ifndef SYNTH
    a_zero_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_length) |->
            (o_magnitude == '0 && o_unit_x == '0 && o_unit_y == '0 && o_unit_z == '0))
        else $error("zero-length result with nonzero fields");
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_unit_x) <= 16'sd16384 && $signed(o_unit_x) >= -16'sd16384))
        else $error("unit x out of range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_magnitude) && $stable(o_unit_x)))
        else $error("stalled result changed");
`endif
endmodule
`default_nettype wire
